@@ hw/rtl/greedy_line_full_justify_defines.svh @@
// Assertion macros shared by the line justification RTL
`ifndef GREEDY_LINE_FULL_JUSTIFY_DEFINES_SVH
`define GREEDY_LINE_FULL_JUSTIFY_DEFINES_SVH

// same-cycle implication
`define GLJF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gljf: same-cycle check failed");

// next-cycle implication
`define GLJF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gljf: next-cycle check failed");

`endif

@@ hw/rtl/gljf_pkg.sv @@
// Shared widths, constants and control/status types for the justification block
package gljf_pkg;

   localparam int WORD_W  = 7;
   localparam int GAP_W   = 6;
   localparam int PAD_W   = 6;
   localparam int WIDTH_W = 7;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

   typedef struct packed {
      logic load;
      logic div_start;
      logic idx_clear;
      logic idx_next;
      logic emit_just;
      logic emit_final;
      logic emit_over;
      logic append;
      logic clear_buf;
   } cmd_type;

   typedef struct packed {
      logic need_close;
      logic single;
      logic oversize;
      logic last;
      logic idx_last;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/gljf_req_if.sv @@
// Request channel interface: word length and end-of-text flag
interface gljf_req_if;
   logic                       valid;
   logic                       ready;
   logic [gljf_pkg::WORD_W-1:0] word_length;
   logic                       last_word;

   modport source (output valid, word_length, last_word, input ready);
   modport sink   (input valid, word_length, last_word, output ready);
endinterface

@@ hw/rtl/gljf_rsp_if.sv @@
// Response channel interface: placement of one word in a justified line
interface gljf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gljf_pkg::WORD_W-1:0] word_size;
   logic [gljf_pkg::GAP_W-1:0]  gap_before;
   logic [gljf_pkg::PAD_W-1:0]  pad_after;
   logic                        line_end;
   logic                        text_end;

   modport source (output valid, word_size, gap_before, pad_after, line_end, text_end,
                   input ready);
   modport sink   (input valid, word_size, gap_before, pad_after, line_end, text_end,
                   output ready);
endinterface

@@ hw/rtl/gljf_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module gljf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gljf_div.sv @@
// Restoring divider, one quotient bit per cycle, for slack over gap count
module gljf_div #(
   parameter int DIVISOR_W = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gljf_pkg::WIDTH_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic                         busy,
   output logic [gljf_pkg::WIDTH_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]         remainder
);

   localparam int QW     = gljf_pkg::WIDTH_W;
   localparam int STEP_W = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QW);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[QW-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/gljf_ctrl.sv @@
// Sequencer for request intake, line closing, word placement and final line walk
module gljf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gljf_pkg::status_type st,
   output gljf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_DIV,
      S_RD_J,
      S_EMIT_J,
      S_PLACE,
      S_OVER,
      S_RD_F,
      S_EMIT_F
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.need_close) begin
               cmd.idx_clear = 1'b1;
               if (st.single) begin
                  state_in = S_RD_J;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DIV: begin
            if (!st.div_busy) begin
               state_in = S_RD_J;
            end
         end
         S_RD_J: begin
            state_in = S_EMIT_J;
         end
         S_EMIT_J: begin
            if (st.out_free) begin
               cmd.emit_just = 1'b1;
               if (st.idx_last) begin
                  cmd.clear_buf = 1'b1;
                  state_in      = S_PLACE;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = S_RD_J;
               end
            end
         end
         S_PLACE: begin
            if (st.oversize) begin
               state_in = S_OVER;
            end else begin
               cmd.append    = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = st.last ? S_RD_F : S_IDLE;
            end
         end
         S_OVER: begin
            if (st.out_free) begin
               cmd.emit_over = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RD_F: begin
            state_in = S_EMIT_F;
         end
         S_EMIT_F: begin
            if (st.out_free) begin
               cmd.emit_final = 1'b1;
               if (st.idx_last) begin
                  cmd.clear_buf = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = S_RD_F;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/gljf_dp.sv @@
// Datapath: width register, word buffer, slack and gap arithmetic, response register
`include "greedy_line_full_justify_defines.svh"

module gljf_dp #(
   parameter int MAX_WIDTH = 64,
   parameter int MAX_WORDS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gljf_pkg::cmd_type            cmd,
   output gljf_pkg::status_type         st,
   input  logic [gljf_pkg::WORD_W-1:0]  word_length,
   input  logic                         last_word,
   input  logic                         csr_write_en,
   input  logic [gljf_pkg::WIDTH_W-1:0] csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gljf_pkg::WORD_W-1:0]  rsp_word_size,
   output logic [gljf_pkg::GAP_W-1:0]   rsp_gap_before,
   output logic [gljf_pkg::PAD_W-1:0]   rsp_pad_after,
   output logic                         rsp_line_end,
   output logic                         rsp_text_end
);

   localparam int WW    = gljf_pkg::WIDTH_W;
   localparam int LW    = gljf_pkg::WORD_W;
   localparam int GW    = gljf_pkg::GAP_W;
   localparam int PW    = gljf_pkg::PAD_W;
   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int SUM_W = $clog2(MAX_WORDS + 2 * (2 ** WW)) + 1;

   logic [WW-1:0]    width_ff, width_in;
   logic [LW-1:0]    word_ff;
   logic             last_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WW-1:0]    total_ff, total_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    size_ff, size_in;
   logic [GW-1:0]    gap_ff, gap_in;
   logic [PW-1:0]    pad_ff, pad_in;
   logic             le_ff, le_in;
   logic             te_ff, te_in;

   logic [WW-1:0]    act_width;
   logic [SUM_W-1:0] fit_sum;
   logic [SUM_W-1:0] used;
   logic [SUM_W-1:0] fin_pad;
   logic [WW-1:0]    slack;
   logic [CNT_W-1:0] divisor;
   logic             div_busy;
   logic [WW-1:0]    quotient;
   logic [CNT_W-1:0] remainder;
   logic [WW:0]      gap_sum;
   logic [GW-1:0]    gap_just;
   logic [LW-1:0]    rd_len;
   logic             idx_last;
   logic             out_free;

   always_comb begin
      if (width_ff == '0) begin
         act_width = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         act_width = WW'(MAX_WIDTH);
      end else begin
         act_width = width_ff;
      end
   end

   assign fit_sum  = SUM_W'(count_ff) + SUM_W'(total_ff) + SUM_W'(word_ff);
   assign slack    = (act_width > total_ff) ? act_width - total_ff : '0;
   assign used     = SUM_W'(total_ff) + SUM_W'(count_ff) - SUM_W'(1);
   assign fin_pad  = (SUM_W'(act_width) > used) ? SUM_W'(act_width) - used : '0;
   assign divisor  = count_ff - CNT_W'(1);
   assign idx_last = CNT_W'(idx_ff) == count_ff - CNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign gap_sum  = (WW + 1)'(quotient) + (WW + 1)'(CNT_W'(idx_ff) <= remainder);
   assign gap_just = (idx_ff == '0) ? '0 : gap_sum[GW-1:0];

   always_comb begin
      st            = '0;
      st.need_close = (count_ff != '0) &&
                      ((count_ff >= CNT_W'(MAX_WORDS)) || (fit_sum > SUM_W'(act_width)));
      st.single     = count_ff == CNT_W'(1);
      st.oversize   = word_ff > act_width;
      st.last       = last_ff;
      st.idx_last   = idx_last;
      st.div_busy   = div_busy;
      st.out_free   = out_free;
   end

   gljf_div #(
      .DIVISOR_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (slack),
      .divisor   (divisor),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   gljf_ram #(
      .DATA_W (LW),
      .DEPTH  (MAX_WORDS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (word_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_len)
   );

   always_comb begin
      width_in = csr_write_en ? csr_write_data : width_ff;

      count_in = count_ff;
      total_in = total_ff;
      if (cmd.clear_buf) begin
         count_in = '0;
         total_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
         total_in = total_ff + WW'(word_ff);
      end

      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      size_in      = size_ff;
      gap_in       = gap_ff;
      pad_in       = pad_ff;
      le_in        = le_ff;
      te_in        = te_ff;
      if (cmd.emit_just) begin
         rsp_valid_in = 1'b1;
         size_in      = rd_len;
         gap_in       = gap_just;
         pad_in       = st.single ? slack[PW-1:0] : '0;
         le_in        = idx_last;
         te_in        = 1'b0;
      end else if (cmd.emit_final) begin
         rsp_valid_in = 1'b1;
         size_in      = rd_len;
         gap_in       = GW'(idx_ff != '0);
         pad_in       = idx_last ? fin_pad[PW-1:0] : '0;
         le_in        = idx_last;
         te_in        = idx_last;
      end else if (cmd.emit_over) begin
         rsp_valid_in = 1'b1;
         size_in      = word_ff;
         gap_in       = '0;
         pad_in       = '0;
         le_in        = 1'b1;
         te_in        = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= gljf_pkg::WIDTH_RESET;
         count_ff     <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= word_length;
         last_ff <= last_word;
      end
      size_ff <= size_in;
      gap_ff  <= gap_in;
      pad_ff  <= pad_in;
      le_ff   <= le_in;
      te_ff   <= te_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_size  = size_ff;
   assign rsp_gap_before = gap_ff;
   assign rsp_pad_after  = pad_ff;
   assign rsp_line_end   = le_ff;
   assign rsp_text_end   = te_ff;

   `GLJF_ASSERT_NOW(a_emit_slot_free, clock, reset,
      cmd.emit_just || cmd.emit_final || cmd.emit_over, out_free)
   `GLJF_ASSERT_NEXT(a_append_counts, clock, reset,
      cmd.append, count_ff == $past(count_ff) + CNT_W'(1))
   `GLJF_ASSERT_NEXT(a_clear_empties, clock, reset,
      cmd.clear_buf, count_ff == '0 && total_ff == '0)
   `GLJF_ASSERT_NEXT(a_div_runs, clock, reset, cmd.div_start, div_busy)

endmodule

@@ hw/rtl/greedy_line_full_justify.sv @@
// Top level of the greedy full-justification layout engine
//
//   channel   direction  handshake           payload
//   req_chan  in         valid/ready         word_length, last_word
//   rsp_chan  out        valid/ready         word_size, gap_before, pad_after,
//                                            line_end, text_end
//   csr       in         csr_write_en        csr_write_data (line width)
//
// One request at a time: the word is taken in S_IDLE, classified in S_DECIDE, placed in S_PLACE.
// Closing a justified line of n > 1 words first runs the slack divider, then walks
// each buffered word through a buffer RAM read and a response load; a one-word line
// skips the divider. The final line walk reads and loads each word the same way.
// A stalled response holds the walk in place; the response register frees the
// request side once the last response of a request is loaded.
// Reset sets the line width to 64 and empties the buffer; buffer RAM is not cleared.
module greedy_line_full_justify #(
   parameter int MAX_WIDTH = 64,
   parameter int MAX_WORDS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   gljf_req_if.sink                     req_chan,
   gljf_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_en,
   input  logic [gljf_pkg::WIDTH_W-1:0] csr_write_data
);

   gljf_pkg::cmd_type    cmd;
   gljf_pkg::status_type st;

   gljf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   gljf_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WORDS (MAX_WORDS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .word_length    (req_chan.word_length),
      .last_word      (req_chan.last_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_word_size  (rsp_chan.word_size),
      .rsp_gap_before (rsp_chan.gap_before),
      .rsp_pad_after  (rsp_chan.pad_after),
      .rsp_line_end   (rsp_chan.line_end),
      .rsp_text_end   (rsp_chan.text_end)
   );

endmodule

@@ tb/tb_greedy_line_full_justify.sv @@
// Self-checking testbench for the greedy full-justification layout engine
`timescale 1ns / 100ps

module tb_greedy_line_full_justify;

   localparam int WORD_W      = gljf_pkg::WORD_W;
   localparam int GAP_W       = gljf_pkg::GAP_W;
   localparam int PAD_W       = gljf_pkg::PAD_W;
   localparam int WIDTH_W     = gljf_pkg::WIDTH_W;
   localparam int LINE_MAX    = 64;
   localparam int BUF_WORDS   = 32;
   localparam int SETTLE_CYC  = 80;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYC    = 300;
   localparam int PHASE_WORDS = 45;

   typedef struct packed {
      logic [WORD_W-1:0] word_size;
      logic [GAP_W-1:0]  gap_before;
      logic [PAD_W-1:0]  pad_after;
      logic              line_end;
      logic              text_end;
   } placement_type;

   typedef struct packed {
      logic              wr;
      logic [WIDTH_W-1:0] wdata;
      logic [WORD_W-1:0] len;
      logic              is_last;
      logic              typed;
      placement_type     place;
   } step_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [WIDTH_W-1:0] csr_write_data;

   gljf_req_if req_chan();
   gljf_rsp_if rsp_chan();

   greedy_line_full_justify DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // layout predictor state
   logic [WIDTH_W-1:0] width_reg;
   int                 line_buf [BUF_WORDS];
   int                 line_count;
   int                 line_sum;
   placement_type      new_places [$];
   placement_type      placements_due [$];

   // request side bookkeeping
   logic          cur_typed;
   placement_type cur_expect;
   int            req_idle_pct;
   int            rsp_idle_pct;
   bit            held_off;

   int words_taken;
   int placements_seen;
   int lines_seen;
   int texts_seen;
   int widths_used;
   int mismatches;
   int stall_cycles;

   step_type directed_steps [0:19];

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int clamp_width(input int w);
      if (w < 1) return 1;
      if (w > LINE_MAX) return LINE_MAX;
      return w;
   endfunction

   function automatic placement_type make_place(input int sz, input int gap, input int pad,
                                                input bit le, input bit te);
      placement_type p;
      p.word_size  = WORD_W'(sz);
      p.gap_before = GAP_W'(gap);
      p.pad_after  = PAD_W'(pad);
      p.line_end   = le;
      p.text_end   = te;
      return p;
   endfunction

   task automatic lay_out_word(input logic [WORD_W-1:0] len, input logic is_last);
      int wid;
      int wl;
      int slack;
      int gap;
      int extra;
      int used;
      int pad;
      int i;
      wid = clamp_width(int'(width_reg));
      wl  = int'(len);
      if (line_count > 0 && (line_count >= BUF_WORDS || line_count + line_sum + wl > wid)) begin
         slack = (wid > line_sum) ? wid - line_sum : 0;
         if (line_count == 1) begin
            new_places.insert(new_places.size(), make_place(line_buf[0], 0, slack, 1'b1, 1'b0));
         end else begin
            gap   = slack / (line_count - 1);
            extra = slack % (line_count - 1);
            for (i = 0; i < line_count; i++) begin
               new_places.insert(new_places.size(), make_place(line_buf[i],
                  (i > 0) ? gap + ((i <= extra) ? 1 : 0) : 0, 0,
                  i == line_count - 1, 1'b0));
            end
         end
         line_count = 0;
         line_sum   = 0;
      end
      if (wl > wid) begin
         new_places.insert(new_places.size(), make_place(wl, 0, 0, 1'b1, is_last));
         return;
      end
      line_buf[line_count] = wl;
      line_count++;
      line_sum += wl;
      if (is_last) begin
         used = line_sum + line_count - 1;
         pad  = (wid > used) ? wid - used : 0;
         for (i = 0; i < line_count; i++) begin
            new_places.insert(new_places.size(), make_place(line_buf[i], (i > 0) ? 1 : 0,
               (i == line_count - 1) ? pad : 0, i == line_count - 1, i == line_count - 1));
         end
         line_count = 0;
         line_sum   = 0;
      end
   endtask

   always @(posedge clock) begin
      placement_type got;
      placement_type due;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (csr_write_en) width_reg = csr_write_data;
         if (req_chan.valid && req_chan.ready) begin
            new_places.delete();
            lay_out_word(req_chan.word_length, req_chan.last_word);
            if (cur_typed) begin
               placements_due.insert(placements_due.size(), cur_expect);
            end else begin
               foreach (new_places[i]) placements_due.insert(placements_due.size(), new_places[i]);
            end
            words_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.word_size  = rsp_chan.word_size;
            got.gap_before = rsp_chan.gap_before;
            got.pad_after  = rsp_chan.pad_after;
            got.line_end   = rsp_chan.line_end;
            got.text_end   = rsp_chan.text_end;
            placements_seen++;
            if (got.line_end) lines_seen++;
            if (got.text_end) texts_seen++;
            if (placements_due.size() == 0) begin
               $error("unexpected placement: word_size %0d gap_before %0d pad_after %0d",
                      got.word_size, got.gap_before, got.pad_after);
               mismatches++;
            end else begin
               due = placements_due.pop_front();
               if (got.word_size !== due.word_size) begin
                  $error("word_size: expected %0d, got %0d", due.word_size, got.word_size);
                  mismatches++;
               end
               if (got.gap_before !== due.gap_before) begin
                  $error("gap_before: expected %0d, got %0d", due.gap_before, got.gap_before);
                  mismatches++;
               end
               if (got.pad_after !== due.pad_after) begin
                  $error("pad_after: expected %0d, got %0d", due.pad_after, got.pad_after);
                  mismatches++;
               end
               if (got.line_end !== due.line_end) begin
                  $error("line_end: expected %0d, got %0d", due.line_end, got.line_end);
                  mismatches++;
               end
               if (got.text_end !== due.text_end) begin
                  $error("text_end: expected %0d, got %0d", due.text_end, got.text_end);
                  mismatches++;
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: %0d placements still due", placements_due.size());
            $display("tb_greedy_line_full_justify: FAIL");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && words_taken >= 40) begin
            held_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYC) @(negedge clock);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] len, input logic is_last,
                            input logic typed, input placement_type place);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.word_length <= len;
      req_chan.last_word   <= is_last;
      cur_typed  = typed;
      cur_expect = place;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] value);
      settle();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      widths_used++;
   endtask

   function automatic logic [WORD_W-1:0] random_length(input int eff);
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return WORD_W'($urandom_range(eff + 1, 127));
      if (r < 9) return '0;
      return WORD_W'($urandom_range(1, eff));
   endfunction

   initial begin
      int            phase;
      int            eff;
      int            sent;
      int            n;
      int            i;
      bit            closed;
      logic [WIDTH_W-1:0] wv;
      placement_type none;

      none                 = '0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.word_length = '0;
      req_chan.last_word   = 1'b0;
      csr_write_en         = 1'b0;
      csr_write_data       = '0;
      cur_typed            = 1'b0;
      cur_expect           = '0;
      held_off             = 1'b0;
      width_reg            = gljf_pkg::WIDTH_RESET;
      line_count           = 0;
      line_sum             = 0;
      words_taken          = 0;
      placements_seen      = 0;
      lines_seen           = 0;
      texts_seen           = 0;
      widths_used          = 0;
      mismatches           = 0;
      req_idle_pct         = 15;
      rsp_idle_pct         = 57;

      directed_steps = '{
         '{1'b0, 7'd0,   7'd64,  1'b1, 1'b1, '{7'd64,  6'd0, 6'd0,  1'b1, 1'b1}},
         '{1'b0, 7'd0,   7'd1,   1'b1, 1'b1, '{7'd1,   6'd0, 6'd63, 1'b1, 1'b1}},
         '{1'b0, 7'd0,   7'd127, 1'b0, 1'b1, '{7'd127, 6'd0, 6'd0,  1'b1, 1'b0}},
         '{1'b0, 7'd0,   7'd10,  1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd20,  1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd30,  1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd5,   1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd0,   1'b1, 1'b0, '0},
         '{1'b0, 7'd0,   7'd0,   1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd0,   1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd64,  1'b1, 1'b0, '0},
         '{1'b1, 7'd1,   7'd1,   1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd1,   1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd2,   1'b1, 1'b0, '0},
         '{1'b1, 7'd0,   7'd1,   1'b1, 1'b1, '{7'd1,   6'd0, 6'd0,  1'b1, 1'b1}},
         '{1'b1, 7'd127, 7'd20,  1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd20,  1'b0, 1'b0, '0},
         '{1'b1, 7'd10,  7'd5,   1'b1, 1'b0, '0},
         '{1'b1, 7'd64,  7'd33,  1'b0, 1'b0, '0},
         '{1'b0, 7'd0,   7'd31,  1'b1, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         if (directed_steps[k].wr) write_width(directed_steps[k].wdata);
         send_word(directed_steps[k].len, directed_steps[k].is_last,
                   directed_steps[k].typed, directed_steps[k].place);
      end

      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct = 57;
            end
            1: begin
               req_idle_pct = 57;
               rsp_idle_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (phase)
            0: wv = 7'd64;
            1: wv = 7'd1;
            3: wv = 7'd33;
            4: wv = 7'd127;
            default: wv = WIDTH_W'($urandom_range(2, 63));
         endcase
         write_width(wv);
         eff  = clamp_width(int'(wv));
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ((sent == 0 && eff >= 63) || ($urandom_range(0, 99) < 8 && eff >= 32)) begin
               // fill the line buffer with tiny words so it closes on count
               n = $urandom_range(33, 40);
               for (i = 0; i < n; i++) begin
                  send_word((eff >= 63) ? WORD_W'($urandom_range(0, 1)) : '0,
                            i == n - 1, 1'b0, none);
               end
            end else begin
               n      = $urandom_range(1, 12);
               closed = ($urandom_range(0, 99) >= 15);
               for (i = 0; i < n; i++) begin
                  send_word(random_length(eff), closed && i == n - 1, 1'b0, none);
               end
            end
            sent += n;
         end
      end

      settle();
      $display("tb_greedy_line_full_justify: %0d requests over %0d line widths",
               words_taken, widths_used);
      $display("tb_greedy_line_full_justify: %0d placements in %0d lines, %0d texts closed",
               placements_seen, lines_seen, texts_seen);
      if (mismatches == 0) begin
         $display("tb_greedy_line_full_justify: PASS");
      end else begin
         $display("tb_greedy_line_full_justify: FAIL");
      end
      $finish;
   end

endmodule
